FILE: sv/tghcm_pkg.sv
// Shared constants, codes and entry types of the tagger hit merge block.
package tghcm_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int EnergyW  = 14;
  localparam int TimeW    = 20;
  localparam int CounterW = 9;
  localparam int EWinW    = 14;
  localparam int TWinW    = 19;
  localparam int CfgDataW = 19;
  localparam int InDataW  = 48;
  localparam int OutDataW = 48;

  typedef enum logic [1:0] {
    FuncMicro = 2'd0,
    FuncHodo  = 2'd1,
    FuncFlush = 2'd2
  } func_e;

  typedef enum logic [0:0] {
    CfgEnergyWin = 1'b0,
    CfgTimeWin   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CounterW-1:0]     counter;
    logic signed [TimeW-1:0] tstamp;
    logic [EnergyW-1:0]      energy;
  } hit_t;

  typedef struct packed {
    logic                    source;
    logic [CounterW-1:0]     counter;
    logic signed [TimeW-1:0] tstamp;
    logic [EnergyW-1:0]      energy;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic hit;
    logic upgrade;
  } match_t;

endpackage

FILE: sv/tghcm_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module tghcm_ram #(
  parameter int DataW = 44,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: sv/tghcm_match.sv
// Window compare of one stored photon against the current hodoscope hit.
module tghcm_match import tghcm_pkg::*; (
  input  entry_t           entry_i,
  input  hit_t             hit_i,
  input  logic [EWinW-1:0] ew_i,
  input  logic [TWinW-1:0] tw_i,
  output match_t           res_o
);

  logic signed [EnergyW:0] de;
  logic        [EnergyW:0] de_abs;
  logic signed [TimeW:0]   dt;
  logic        [TimeW:0]   dt_abs;

  always_comb begin
    de     = $signed({1'b0, entry_i.energy}) - $signed({1'b0, hit_i.energy});
    de_abs = de[EnergyW] ? (EnergyW+1)'(0) - de : de;
    // sign-extend both times by one bit so the difference cannot wrap
    dt     = $signed({entry_i.tstamp[TimeW-1], entry_i.tstamp})
           - $signed({hit_i.tstamp[TimeW-1], hit_i.tstamp});
    dt_abs = dt[TimeW] ? (TimeW+1)'(0) - dt : dt;
    res_o.hit     = (de_abs < {1'b0, ew_i}) && (dt_abs < {2'b00, tw_i});
    res_o.upgrade = res_o.hit && (entry_i.energy < hit_i.energy);
  end

endmodule

FILE: sv/tagger_hit_coincidence_merge.sv
// Top level: photon table sequencer around one table RAM.
//
//  channel  | handshake               | contents
//  s_axis   | tvalid/tready           | tuser func; tdata hit fields
//  m_axis   | tvalid/tready, tlast    | tuser source; tdata photon fields
//  cfg      | cfg_we_i, no stall      | cfg_idx_i register, cfg_data_i value
//
// Microscope hits, ignored items and empty flushes finish in the accept cycle.
// A hodoscope hit scans the N stored photons, also on an empty table:
// one RAM read per cycle, compare and write-back in the cycle after each read,
// a step to settle the match flag, then a closing append step.
// An end of event passes each photon, one at a time, through the single read port
// and output register, and waits while m_axis stalls.
// Reset clears count and overflow flag and sets the windows to 50 and 150; RAM is not cleared.
module tagger_hit_coincidence_merge import tghcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // has_adc, fiber_row, hit_energy,
                                             // hit_time, counter_number, pad
  input  logic [1:0]          s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // photon_energy, photon_time,
                                             // photon_counter, table_overflowed, pad
  output logic                m_axis_tuser,  // photon_source
  output logic                m_axis_tlast,  // last_photon
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAppend,
    StFlush
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              scan_pend_q, scan_pend_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              matched_q, matched_d;
  hit_t              hit_q, hit_d;
  logic              fl_pend_q, fl_pend_d;
  logic              fl_last_q, fl_last_d;
  logic              fl_ovf_q, fl_ovf_d;
  logic              out_valid_q, out_valid_d;
  entry_t            out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;
  logic [EWinW-1:0]  ew_q;
  logic [TWinW-1:0]  tw_q;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  entry_t            ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t            rd_entry;
  match_t            mres;

  logic              s_acc;
  logic              in_adc;
  logic [2:0]        in_row;
  hit_t              in_hit;
  logic              table_full;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_adc        = s_axis_tdata[0];
  assign in_row        = s_axis_tdata[3:1];
  assign in_hit        = hit_t'(s_axis_tdata[46:4]);
  assign rd_entry      = entry_t'(ram_rdata);
  assign table_full    = (count_q >= CntW'(TableDepth));

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_ovf_q, out_q.counter, out_q.tstamp, out_q.energy};
  assign m_axis_tuser  = out_q.source;
  assign m_axis_tlast  = out_last_q;

  tghcm_ram #(
    .DataW (EntryW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tghcm_match u_match (
    .entry_i (rd_entry),
    .hit_i   (hit_q),
    .ew_i    (ew_q),
    .tw_i    (tw_q),
    .res_o   (mres)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    rd_idx_d    = rd_idx_q;
    scan_pend_d = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    matched_d   = matched_q;
    hit_d       = hit_q;
    fl_pend_d   = 1'b0;
    fl_last_d   = fl_last_q;
    fl_ovf_d    = fl_ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[IdxW-1:0];
    ram_wdata   = {1'b0, in_hit};
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IdxW-1:0];

    // output register: drop on take, load read data in the cycle after a flush read
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (fl_pend_q) begin
      out_valid_d = 1'b1;
      out_d       = rd_entry;
      out_last_d  = fl_last_q;
      out_ovf_d   = fl_ovf_q;
    end

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          case (s_axis_tuser)
            FuncMicro: begin
              if (in_adc && (in_row == 3'd0)) begin
                if (table_full) begin
                  ovf_d = 1'b1;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, in_hit};
                  count_d   = count_q + CntW'(1);
                end
              end
            end
            FuncHodo: begin
              if (in_adc) begin
                hit_d     = in_hit;
                rd_idx_d  = '0;
                matched_d = 1'b0;
                state_d   = StScan;
              end
            end
            FuncFlush: begin
              if (count_q == '0) begin
                ovf_d = 1'b0;
              end else begin
                rd_idx_d = '0;
                state_d  = StFlush;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (rd_idx_q != count_q) begin
          ram_re      = 1'b1;
          rd_idx_d    = rd_idx_q + CntW'(1);
          scan_pend_d = 1'b1;
          cmp_idx_d   = rd_idx_q[IdxW-1:0];
        end
        if (scan_pend_q) begin
          if (mres.hit) begin
            matched_d = 1'b1;
          end
          // overwrite the entry just compared; the next read is another entry
          if (mres.upgrade) begin
            ram_we    = 1'b1;
            ram_waddr = cmp_idx_q;
            ram_wdata = {1'b1, hit_q};
          end
        end
        if ((rd_idx_q == count_q) && !scan_pend_q) begin
          state_d = StAppend;
        end
      end
      StAppend: begin
        if (!matched_q) begin
          if (table_full) begin
            ovf_d = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, hit_q};
            count_d   = count_q + CntW'(1);
          end
        end
        state_d = StIdle;
      end
      StFlush: begin
        if (!fl_pend_q && (!out_valid_q || m_axis_tready)) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CntW'(1);
          fl_pend_d = 1'b1;
          fl_last_d = ((rd_idx_q + CntW'(1)) == count_q);
          fl_ovf_d  = ovf_q;
          if ((rd_idx_q + CntW'(1)) == count_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      scan_pend_q <= 1'b0;
      cmp_idx_q   <= '0;
      matched_q   <= 1'b0;
      hit_q       <= '0;
      fl_pend_q   <= 1'b0;
      fl_last_q   <= 1'b0;
      fl_ovf_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      ew_q        <= EWinW'(50);
      tw_q        <= TWinW'(150);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      scan_pend_q <= scan_pend_d;
      cmp_idx_q   <= cmp_idx_d;
      matched_q   <= matched_d;
      hit_q       <= hit_d;
      fl_pend_q   <= fl_pend_d;
      fl_last_q   <= fl_last_d;
      fl_ovf_q    <= fl_ovf_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgEnergyWin: ew_q <= cfg_data_i[EWinW-1:0];
          CfgTimeWin:   tw_q <= cfg_data_i[TWinW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/tghcm_checker.sv
// Port-level checks of the tagger hit merge block, bound to the top level.
module tghcm_checker import tghcm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [1:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result item changed");

  // no result item straight after a reset edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // microscope hits and ignored items finish in the accept cycle
  a_micro_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser != FuncFlush) && (s_axis_tuser != FuncHodo || !s_axis_tdata[0])
      |=> s_axis_tready)
    else $error("single-cycle item held the input");

  // a hodoscope hit with ADC data always starts a table scan
  a_hodo_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == FuncHodo && s_axis_tdata[0] |=> !s_axis_tready)
    else $error("hodoscope hit skipped the scan");

endmodule

bind tagger_hit_coincidence_merge tghcm_checker u_tghcm_checker (.*);
